/* design/ptts_pkg.sv */
package ptts_pkg;

    localparam int SLOTS_DEF = 8;
    localparam int ID_W      = 4;
    localparam int LAP_W     = 16;
    localparam int PRIO_W    = 8;
    localparam int RES_W     = 8;
    localparam int DIV_W     = RES_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 8;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_TICK_RES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LAP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIO_MODE = 2'd2;

    // input opcodes; in the queue a tick that completes the prescaler stays
    // OP_TICK and one that does not becomes OP_NOP
    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_DELETE = 2'd1,
        OP_TICK   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ID_W-1:0]   id;
        logic [LAP_W-1:0]  period;
        logic              is_single;
        logic [PRIO_W-1:0] prio;
        logic              lap_ok;
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LAP_W-1:0]  period;
        logic [LAP_W-1:0]  count;
        logic [PRIO_W-1:0] prio;
        logic              is_single;
    } entry_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_C_SCAN,
        B_C_SHIFT,
        B_D_SCAN,
        B_D_MOVE,
        B_T_WALK,
        B_T_REMOVE,
        B_EMIT
    } back_state_t;

endpackage

/* design/ptts_front.sv */
module ptts_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ptts_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [ptts_pkg::RES_W-1:0]   tick_res,
    input  logic [ptts_pkg::LAP_W-1:0]   max_lap,
    output logic                         push_valid,
    input  logic                         push_ready,
    output ptts_pkg::cmd_t               push_cmd
);
    import ptts_pkg::*;

    localparam int STEP_W = $clog2(LAP_W);

    front_state_t             state_reg, state_next;
    cmd_t                     cmd_reg, cmd_next;
    logic [LAP_W-1:0]         dq_reg, dq_next;
    logic [RES_W-1:0]         rem_reg, rem_next;
    logic                     rem_hi_reg, rem_hi_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [RES_W-1:0]         pre_reg, pre_next;

    logic                     accept;
    logic [1:0]               in_op;
    logic [ID_W-1:0]          in_id;
    logic [LAP_W-1:0]         in_lap;
    logic                     in_shot;
    logic [PRIO_W-1:0]        in_prio;
    logic [DIV_W-1:0]         divisor;
    logic [DIV_W:0]           trial;
    logic [DIV_W:0]           diff;
    logic                     ge;
    logic [RES_W-1:0]         pre_inc;

    assign in_op   = s_tdata[1:0];
    assign in_id   = s_tdata[5:2];
    assign in_lap  = s_tdata[21:6];
    assign in_shot = s_tdata[22];
    assign in_prio = s_tdata[30:23];

    assign accept  = s_tvalid && s_tready;
    // resolution 0 means 256
    assign divisor = (tick_res == '0) ? DIV_W'(1 << RES_W) : {1'b0, tick_res};
    // one restoring step per cycle
    assign trial   = {rem_hi_reg, rem_reg, dq_reg[LAP_W-1]};
    assign ge      = trial >= {1'b0, divisor};
    assign diff    = trial - {1'b0, divisor};
    assign pre_inc = pre_reg + RES_W'(1);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    state_next = (in_op == OP_CREATE) ? F_DIV : F_PUSH;
                end
            end
            F_DIV: begin
                if (step_reg == STEP_W'(LAP_W - 1)) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (push_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = (state_reg == F_IDLE);
        push_valid  = (state_reg == F_PUSH);
        cmd_next    = cmd_reg;
        dq_next     = dq_reg;
        rem_next    = rem_reg;
        rem_hi_next = rem_hi_reg;
        step_next   = step_reg;
        pre_next    = pre_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    cmd_next.op        = op_t'(in_op);
                    cmd_next.id        = in_id;
                    cmd_next.is_single = in_shot;
                    cmd_next.prio      = in_prio;
                    cmd_next.lap_ok    = (in_lap <= max_lap);
                    cmd_next.period    = '0;
                    dq_next            = in_lap;
                    rem_next           = '0;
                    rem_hi_next        = 1'b0;
                    step_next          = '0;
                    if (in_op == OP_TICK) begin
                        if (pre_inc == tick_res) begin
                            pre_next = '0;
                        end else begin
                            pre_next    = pre_inc;
                            cmd_next.op = OP_NOP;
                        end
                    end
                end
            end
            F_DIV: begin
                dq_next   = {dq_reg[LAP_W-2:0], ge};
                step_next = step_reg + STEP_W'(1);
                if (ge) begin
                    {rem_hi_next, rem_next} = diff[DIV_W-1:0];
                end else begin
                    {rem_hi_next, rem_next} = trial[DIV_W-1:0];
                end
            end
            F_PUSH: ;
            default: ;
        endcase
    end

    always_comb begin
        push_cmd        = cmd_reg;
        push_cmd.period = dq_reg;
        push_cmd.lap_ok = cmd_reg.lap_ok && (rem_reg == '0) && !rem_hi_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            pre_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pre_reg   <= pre_next;
        end
        cmd_reg    <= cmd_next;
        dq_reg     <= dq_next;
        rem_reg    <= rem_next;
        rem_hi_reg <= rem_hi_next;
        step_reg   <= step_next;
    end

endmodule

/* design/ptts_queue.sv */
module ptts_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  ptts_pkg::cmd_t wr_cmd,
    output logic           rd_valid,
    input  logic           rd_pop,
    output ptts_pkg::cmd_t rd_cmd
);
    import ptts_pkg::*;

    localparam int DEPTH = 2;

    cmd_t       slot_reg [DEPTH];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_wr, do_rd;

    assign wr_ready = (fill_reg != 2'(DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_cmd   = slot_reg[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;

    always_comb begin
        wp_next   = do_wr ? ~wp_reg : wp_reg;
        rp_next   = do_rd ? ~rp_reg : rp_reg;
        fill_next = fill_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fill_reg <= '0;
        end else begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            fill_reg <= fill_next;
        end
        if (do_wr) begin
            slot_reg[wp_reg] <= wr_cmd;
        end
    end

endmodule

/* design/ptts_back.sv */
module ptts_back #(
    parameter int SLOTS = ptts_pkg::SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  ptts_pkg::cmd_t                q_cmd,
    input  logic                          prio_mode,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ptts_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import ptts_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int MAP_W = SLOTS + 1;

    back_state_t       state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MAP_W-1:0]  taken_reg, taken_next;
    logic              pend_reg, pend_next;
    logic [ID_W-1:0]   pend_id_reg, pend_id_next;
    logic              res_st_reg, res_st_next;
    logic              res_fi_reg, res_fi_next;
    logic [ID_W-1:0]   res_id_reg, res_id_next;
    logic              mv_reg, mv_next;
    logic [M_DATA_W-1:0] md_reg, md_next;
    logic              ml_reg, ml_next;

    entry_t            ent_mem [SLOTS];
    logic [CNT_W-1:0]  rd_idx;
    entry_t            rd_ent;
    logic              wr_en;
    logic [CNT_W-1:0]  wr_idx;
    entry_t            wr_ent;

    logic              out_free;
    logic              id_ok;
    logic              id_taken;
    logic [MAP_W-1:0]  id_mask;
    logic [MAP_W-1:0]  pend_mask;
    logic [LAP_W-1:0]  cnt_inc;
    logic              hit;
    logic              stall;

    assign out_free = !mv_reg || m_tready;
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;

    // id checks use the queue head in idle and the held command later
    always_comb begin
        logic [ID_W-1:0] cid;
        cid = (state_reg == B_IDLE) ? q_cmd.id : cmd_reg.id;
        id_ok = (32'(cid) <= SLOTS);
        for (int k = 0; k < MAP_W; k++) begin
            id_mask[k]   = (32'(cid) == k);
            pend_mask[k] = (32'(pend_id_reg) == k);
        end
        id_taken = |(taken_reg & id_mask);
    end

    always_comb begin
        unique case (state_reg)
            B_C_SHIFT:            rd_idx = idx_reg - CNT_W'(1);
            B_D_MOVE, B_T_REMOVE: rd_idx = cnt_reg - CNT_W'(1);
            default:              rd_idx = idx_reg;
        endcase
    end
    assign rd_ent  = ent_mem[rd_idx[IDX_W-1:0]];
    assign cnt_inc = rd_ent.count + LAP_W'(1);
    assign hit     = (cnt_inc == rd_ent.period);
    assign stall   = hit && pend_reg && !out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    unique case (q_cmd.op)
                        OP_CREATE: begin
                            if (!(q_cmd.lap_ok && id_ok && !id_taken &&
                                  32'(cnt_reg) < SLOTS)) begin
                                state_next = B_EMIT;
                            end else if (prio_mode) begin
                                state_next = B_C_SCAN;
                            end else begin
                                state_next = B_C_SHIFT;
                            end
                        end
                        OP_DELETE: state_next = (id_ok && id_taken) ? B_D_SCAN : B_EMIT;
                        OP_TICK:   state_next = B_T_WALK;
                        default:   state_next = B_EMIT;
                    endcase
                end
            end
            B_C_SCAN: begin
                if (idx_reg == cnt_reg || rd_ent.prio >= cmd_reg.prio) begin
                    state_next = B_C_SHIFT;
                end
            end
            B_C_SHIFT: begin
                if (idx_reg == pos_reg) begin
                    state_next = B_EMIT;
                end
            end
            B_D_SCAN: begin
                if (idx_reg == cnt_reg) begin
                    state_next = B_EMIT;
                end else if (rd_ent.id == cmd_reg.id) begin
                    state_next = B_D_MOVE;
                end
            end
            B_D_MOVE: state_next = B_EMIT;
            B_T_WALK: begin
                // removing the tail entry leaves idx one past the count
                if (idx_reg >= cnt_reg) begin
                    state_next = B_EMIT;
                end else if (!stall && hit && rd_ent.is_single) begin
                    state_next = B_T_REMOVE;
                end
            end
            B_T_REMOVE: state_next = B_T_WALK;
            B_EMIT: begin
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        q_pop        = 1'b0;
        cmd_next     = cmd_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        cnt_next     = cnt_reg;
        taken_next   = taken_reg;
        pend_next    = pend_reg;
        pend_id_next = pend_id_reg;
        res_st_next  = res_st_reg;
        res_fi_next  = res_fi_reg;
        res_id_next  = res_id_reg;
        mv_next      = mv_reg && !m_tready;
        md_next      = md_reg;
        ml_next      = ml_reg;
        wr_en        = 1'b0;
        wr_idx       = idx_reg;
        wr_ent       = rd_ent;
        unique case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    q_pop       = 1'b1;
                    cmd_next    = q_cmd;
                    idx_next    = '0;
                    pend_next   = 1'b0;
                    res_st_next = 1'b0;
                    res_fi_next = 1'b0;
                    res_id_next = '0;
                    unique case (q_cmd.op)
                        OP_CREATE: begin
                            res_st_next = !(q_cmd.lap_ok && id_ok && !id_taken &&
                                            32'(cnt_reg) < SLOTS);
                            if (!prio_mode) begin
                                pos_next = cnt_reg;
                                idx_next = cnt_reg;
                            end
                        end
                        OP_DELETE: res_st_next = !(id_ok && id_taken);
                        default: ;
                    endcase
                end
            end
            B_C_SCAN: begin
                if (idx_reg == cnt_reg || rd_ent.prio >= cmd_reg.prio) begin
                    pos_next = idx_reg;
                    idx_next = cnt_reg;
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            B_C_SHIFT: begin
                wr_en = 1'b1;
                if (idx_reg == pos_reg) begin
                    wr_ent.id        = cmd_reg.id;
                    wr_ent.period    = cmd_reg.period;
                    wr_ent.count     = '0;
                    wr_ent.prio      = cmd_reg.prio;
                    wr_ent.is_single = cmd_reg.is_single;
                    cnt_next         = cnt_reg + CNT_W'(1);
                    taken_next       = taken_reg | id_mask;
                end else begin
                    idx_next = idx_reg - CNT_W'(1);
                end
            end
            B_D_SCAN: begin
                if (idx_reg == cnt_reg) begin
                    taken_next = taken_reg & ~id_mask;
                end else if (rd_ent.id != cmd_reg.id) begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            B_D_MOVE: begin
                wr_en      = 1'b1;
                cnt_next   = cnt_reg - CNT_W'(1);
                taken_next = taken_reg & ~id_mask;
            end
            B_T_WALK: begin
                if (idx_reg >= cnt_reg) begin
                    res_fi_next = pend_reg;
                    res_id_next = pend_reg ? pend_id_reg : '0;
                end else if (!stall) begin
                    wr_en        = 1'b1;
                    wr_ent.count = hit ? '0 : cnt_inc;
                    if (hit) begin
                        if (pend_reg) begin
                            mv_next = 1'b1;
                            md_next = M_DATA_W'({pend_id_reg, 1'b1, 1'b0});
                            ml_next = 1'b0;
                        end
                        pend_next    = 1'b1;
                        pend_id_next = rd_ent.id;
                    end
                    if (!(hit && rd_ent.is_single)) begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
            end
            B_T_REMOVE: begin
                wr_en      = 1'b1;
                cnt_next   = cnt_reg - CNT_W'(1);
                taken_next = taken_reg & ~pend_mask;
                idx_next   = idx_reg + CNT_W'(1);
            end
            B_EMIT: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    md_next = M_DATA_W'({res_id_reg, res_fi_reg, res_st_reg});
                    ml_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            cnt_reg   <= '0;
            taken_reg <= '0;
            pend_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            taken_reg <= taken_next;
            pend_reg  <= pend_next;
            mv_reg    <= mv_next;
        end
        cmd_reg     <= cmd_next;
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        pend_id_reg <= pend_id_next;
        res_st_reg  <= res_st_next;
        res_fi_reg  <= res_fi_next;
        res_id_reg  <= res_id_next;
        md_reg      <= md_next;
        ml_reg      <= ml_next;
        if (wr_en) begin
            ent_mem[wr_idx[IDX_W-1:0]] <= wr_ent;
        end
    end

endmodule

/* design/priority_task_tick_scheduler.sv */
// Timed-task table with a tick prescaler.
// Input beats (s_*): create, delete, raw timer tick or no-op. Each input beat
// gives one or more result beats on m_*, the final one marked by m_tlast.
// Create/delete/no-op and a tick that does not finish the prescaler give a
// single beat (status, fired=0). A completed scheduler tick walks the table
// in order and gives one beat per fired task, or one empty beat.
// Config port (cfg_*): index 0 tick resolution, 1 max lap time, 2 priority
// mode; cfg_ready is always high; write only while the block is idle.
// A create divides the lap time by the resolution in the front, is pushed to
// the queue, then the back scans for its slot (priority mode only) and shifts
// entries up to make room; each one-shot removal adds a step to a scheduler
// tick walk. The front takes the next beat once it has pushed the previous command.
// A two-deep queue between front and back lets the front take the next beat
// while the back works; a full output register stalls the table walk when
// the receiver holds m_tready low, nothing is dropped.
// Reset (aresetn low, synchronous) empties the table, clears all ids and the
// prescaler, and loads resolution 1, max lap 65535, priority mode on.
module priority_task_tick_scheduler #(
    parameter int SLOTS = ptts_pkg::SLOTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // opcode[1:0], task_id[5:2], lap[21:6], single[22], priority_req[30:23]
    input  logic [ptts_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status[0], fired[1], fired_id[5:2]
    output logic [ptts_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ptts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ptts_pkg::CFG_DAT_W-1:0] cfg_data
);
    import ptts_pkg::*;

    logic [RES_W-1:0] res_reg;
    logic [LAP_W-1:0] max_lap_reg;
    logic             prio_mode_reg;

    logic push_valid, push_ready;
    cmd_t push_cmd;
    logic q_valid, q_pop;
    cmd_t q_cmd;

    assign cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg       <= RES_W'(1);
            max_lap_reg   <= '1;
            prio_mode_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_TICK_RES:  res_reg       <= cfg_data[RES_W-1:0];
                REG_MAX_LAP:   max_lap_reg   <= cfg_data[LAP_W-1:0];
                REG_PRIO_MODE: prio_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // front end: decode, prescaler, lap-time divide and checks
    ptts_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .tick_res   (res_reg),
        .max_lap    (max_lap_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    ptts_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_cmd   (push_cmd),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_cmd   (q_cmd)
    );

    // back end: table sequencer and result register
    ptts_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd),
        .prio_mode (prio_mode_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

/* verif/tb_priority_task_tick_scheduler.sv */
`timescale 1ns / 100ps

module tb_priority_task_tick_scheduler;
    import ptts_pkg::*;

    localparam int SLOTS     = SLOTS_DEF;
    localparam int STALL_MAX = 10;
    localparam int WDOG_MAX  = 5000;  // quiet cycles allowed before we give up
    localparam int DRAIN     = 40;    // settle cycles after the last result

    // one result beat
    typedef struct {
        bit       status;
        bit       fired;
        bit [3:0] fired_id;
        bit       last;
    } beat_t;

    // one directed row; chk rows carry a typed-in expectation
    typedef struct {
        op_t      op;
        bit [3:0] id;
        bit [15:0] lap;
        bit       shot;
        bit [7:0] prio;
        bit       chk;
        bit       st;
    } row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;   // opcode, task_id, lap, single-run flag, priority_req
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;   // status, fired, fired_id
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DAT_W-1:0]  cfg_data;

    always #2 aclk = ~aclk;

    priority_task_tick_scheduler #(.SLOTS(SLOTS)) dut (.*);

    // ---------------------------------------------------------------
    // Scheduler shadow: config, table, id map and prescaler
    // ---------------------------------------------------------------
    bit [7:0]  sh_res;
    bit [15:0] sh_max_lap;
    bit        sh_prio_mode;
    bit [3:0]  tbl_id     [SLOTS];
    bit [15:0] tbl_period [SLOTS];
    bit [15:0] tbl_count  [SLOTS];
    bit [7:0]  tbl_prio   [SLOTS];
    bit        tbl_shot   [SLOTS];
    int        tbl_used;
    bit [8:0]  id_taken;
    bit [7:0]  prescale;

    beat_t expected_beats[$];

    int  errs, n_items, n_beats, n_fired;
    bit  no_idle;
    int  quiet;

    function automatic int eff_res();
        return (sh_res == 0) ? 256 : int'(sh_res);
    endfunction

    function automatic void tbl_copy(int dst, int src);
        tbl_id[dst]     = tbl_id[src];
        tbl_period[dst] = tbl_period[src];
        tbl_count[dst]  = tbl_count[src];
        tbl_prio[dst]   = tbl_prio[src];
        tbl_shot[dst]   = tbl_shot[src];
    endfunction

    // swap-with-last removal, same as the block's delete
    function automatic void tbl_remove(int slot);
        id_taken[tbl_id[slot]] = 1'b0;
        tbl_copy(slot, tbl_used - 1);
        tbl_used--;
    endfunction

    function automatic bit sched_create(bit [3:0] id, bit [15:0] lap, bit shot,
                                        bit [7:0] prio);
        int pos;
        if (id > SLOTS || id_taken[id] || lap > sh_max_lap || (int'(lap) % eff_res()) != 0 ||
            tbl_used >= SLOTS)
            return 1'b1;
        pos = tbl_used;
        if (sh_prio_mode) begin
            for (int i = 0; i < tbl_used; i++) begin
                if (tbl_prio[i] >= prio) begin
                    pos = i;
                    break;
                end
            end
        end
        for (int i = tbl_used; i > pos; i--) tbl_copy(i, i - 1);
        tbl_id[pos]     = id;
        tbl_period[pos] = 16'(int'(lap) / eff_res());
        tbl_count[pos]  = '0;
        tbl_prio[pos]   = prio;
        tbl_shot[pos]   = shot;
        tbl_used++;
        id_taken[id] = 1'b1;
        return 1'b0;
    endfunction

    function automatic bit sched_delete(bit [3:0] id);
        if (id > SLOTS || !id_taken[id]) return 1'b1;
        for (int i = 0; i < tbl_used; i++) begin
            if (tbl_id[i] == id) begin
                tbl_remove(i);
                break;
            end
        end
        id_taken[id] = 1'b0;
        return 1'b0;
    endfunction

    // advance the shadow by one input beat; queue what it should produce
    function automatic void sched_step(op_t op, bit [3:0] id, bit [15:0] lap, bit shot,
                                       bit [7:0] prio, bit push);
        beat_t q[$];
        beat_t b;
        int    i;
        b = '{0, 0, 0, 1};
        case (op)
            OP_CREATE: b.status = sched_create(id, lap, shot, prio);
            OP_DELETE: b.status = sched_delete(id);
            OP_TICK: begin
                prescale = prescale + 8'd1;
                if (prescale == sh_res) begin  // res 0 matches after the 8-bit wrap
                    prescale = '0;
                    i = 0;
                    while (i < tbl_used) begin
                        tbl_count[i] = tbl_count[i] + 16'd1;
                        if (tbl_count[i] == tbl_period[i]) begin
                            tbl_count[i] = '0;
                            q.push_back('{0, 1, tbl_id[i], 0});
                            // entry moved in from the tail is skipped this pass
                            if (tbl_shot[i]) tbl_remove(i);
                        end
                        i++;
                    end
                end
            end
            default: ;
        endcase
        if (q.size() == 0) q.push_back(b);
        q[$].last = 1'b1;
        if (push) foreach (q[k]) expected_beats.push_back(q[k]);
    endfunction

    // ---------------------------------------------------------------
    // Input side: one beat per call, random hold-off before it
    // ---------------------------------------------------------------
    task automatic send_cmd(op_t op, bit [3:0] id, bit [15:0] lap, bit shot, bit [7:0] prio,
                            bit typed, bit typed_st);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, STALL_MAX);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, prio, shot, lap, id, op};
        do @(posedge aclk); while (!s_tready);
        n_items++;
        sched_step(op, id, lap, shot, prio, !typed);
        if (typed) expected_beats.push_back('{typed_st, 0, 0, 1});
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic cfg_write(bit [CFG_IDX_W-1:0] idx, bit [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TICK_RES:  sh_res       = val[7:0];
            REG_MAX_LAP:   sh_max_lap   = val;
            REG_PRIO_MODE: sh_prio_mode = val[0];
            default: ;
        endcase
    endtask

    task automatic set_cfg(bit [7:0] res, bit [15:0] max_lap, bit mode);
        cfg_write(REG_TICK_RES, {8'd0, res});
        cfg_write(REG_MAX_LAP, max_lap);
        cfg_write(REG_PRIO_MODE, {15'd0, mode});
    endtask

    // mostly well-formed commands and ticks, some bad ids and bad lap times
    task automatic send_random(int cnt);
        op_t       op;
        bit [3:0]  id;
        bit [15:0] lap;
        int        r;
        repeat (cnt) begin
            r  = $urandom_range(0, 99);
            op = (r < 35) ? OP_CREATE : (r < 55) ? OP_DELETE : (r < 95) ? OP_TICK : OP_NOP;
            id = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, SLOTS))
                                              : 4'($urandom_range(SLOTS + 1, 15));
            r  = $urandom_range(0, 9);
            if (r < 6)      lap = 16'(eff_res() * $urandom_range(0, 5));
            else if (r < 8) lap = 16'($urandom);
            else            lap = 16'(eff_res() * $urandom_range(0, 3) + 1);
            send_cmd(op, id, lap, 1'($urandom), 8'($urandom), 1'b0, 1'b0);
        end
    endtask

    // ---------------------------------------------------------------
    // Result side: random back-pressure per beat, compare in order
    // ---------------------------------------------------------------
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, STALL_MAX);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge aclk) begin
        beat_t e;
        if (aresetn && m_tvalid && m_tready) begin
            n_beats++;
            if (expected_beats.size() == 0) begin
                $error("result beat with nothing expected: tdata=%h tlast=%b",
                       m_tdata, m_tlast);
                errs++;
            end else begin
                e = expected_beats.pop_front();
                if (e.fired) n_fired++;
                if (m_tdata[0] !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, m_tdata[0]);
                    errs++;
                end
                if (m_tdata[1] !== e.fired) begin
                    $error("fired: expected %0d, got %0d", e.fired, m_tdata[1]);
                    errs++;
                end
                if (m_tdata[5:2] !== e.fired_id) begin
                    $error("fired_id: expected %0d, got %0d", e.fired_id, m_tdata[5:2]);
                    errs++;
                end
                if (m_tlast !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, m_tlast);
                    errs++;
                end
            end
        end
    end

    // watchdog: any beat on any channel counts as progress
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= WDOG_MAX) begin
            $display("watchdog expired, %0d beats still expected", expected_beats.size());
            $display("Mismatches found");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // ---------------------------------------------------------------
    // Directed rows, run with the reset configuration
    // ---------------------------------------------------------------
    row_t dir_rows[] = '{
        '{OP_TICK,   4'd0,  16'd0,     1'b0, 8'd0,   1'b1, 1'b0}, // empty table tick
        '{OP_NOP,    4'd5,  16'hffff,  1'b1, 8'hff,  1'b1, 1'b0}, // unused opcode
        '{OP_CREATE, 4'd9,  16'd4,     1'b0, 8'd1,   1'b1, 1'b1}, // id out of range
        '{OP_CREATE, 4'd15, 16'hffff,  1'b1, 8'hff,  1'b1, 1'b1}, // id out of range
        '{OP_DELETE, 4'd4,  16'd0,     1'b0, 8'd0,   1'b1, 1'b1}, // id not taken
        '{OP_DELETE, 4'd15, 16'd0,     1'b0, 8'd0,   1'b1, 1'b1}, // id out of range
        '{OP_CREATE, 4'd0,  16'd0,     1'b0, 8'hff,  1'b0, 1'b0}, // zero period
        '{OP_CREATE, 4'd8,  16'hffff,  1'b1, 8'h00,  1'b0, 1'b0}, // max lap, top id
        '{OP_CREATE, 4'd1,  16'd1,     1'b1, 8'h80,  1'b0, 1'b0},
        '{OP_CREATE, 4'd2,  16'd2,     1'b0, 8'h80,  1'b0, 1'b0}, // equal priority
        '{OP_CREATE, 4'd3,  16'd1,     1'b1, 8'h01,  1'b0, 1'b0},
        '{OP_CREATE, 4'd0,  16'd5,     1'b0, 8'h10,  1'b1, 1'b1}, // id taken
        '{OP_TICK,   4'd0,  16'd0,     1'b0, 8'd0,   1'b0, 1'b0}, // one-shots fire, skip
        '{OP_TICK,   4'd0,  16'd0,     1'b0, 8'd0,   1'b0, 1'b0},
        '{OP_CREATE, 4'd4,  16'd3,     1'b0, 8'h55,  1'b0, 1'b0},
        '{OP_CREATE, 4'd5,  16'd1,     1'b1, 8'haa,  1'b0, 1'b0},
        '{OP_CREATE, 4'd6,  16'd2,     1'b0, 8'h7f,  1'b0, 1'b0},
        '{OP_CREATE, 4'd7,  16'd1,     1'b0, 8'hfe,  1'b0, 1'b0},
        '{OP_CREATE, 4'd1,  16'd1,     1'b1, 8'h00,  1'b0, 1'b0},
        '{OP_CREATE, 4'd3,  16'd1,     1'b0, 8'h02,  1'b1, 1'b1}, // table full
        '{OP_TICK,   4'd0,  16'd0,     1'b0, 8'd0,   1'b0, 1'b0},
        '{OP_TICK,   4'd0,  16'd0,     1'b0, 8'd0,   1'b0, 1'b0},
        '{OP_DELETE, 4'd8,  16'd0,     1'b0, 8'd0,   1'b0, 1'b0},
        '{OP_DELETE, 4'd0,  16'd0,     1'b0, 8'd0,   1'b0, 1'b0},
        '{OP_TICK,   4'd0,  16'd0,     1'b0, 8'd0,   1'b0, 1'b0}
    };

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        sh_res = 8'd1;
        sh_max_lap = 16'hffff;
        sh_prio_mode = 1'b1;
        tbl_used = 0;
        id_taken = '0;
        prescale = '0;
        errs = 0;
        n_items = 0;
        n_beats = 0;
        n_fired = 0;
        no_idle = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[k])
            send_cmd(dir_rows[k].op, dir_rows[k].id, dir_rows[k].lap, dir_rows[k].shot,
                     dir_rows[k].prio, dir_rows[k].chk, dir_rows[k].st);
        go_idle();

        // append mode, resolution 4
        set_cfg(8'd4, 16'd40000, 1'b0);
        send_random(40);
        go_idle();

        // zero resolution acts as 256
        set_cfg(8'd0, 16'hffff, 1'b1);
        send_random(20);
        go_idle();

        // resolution 255 and max lap 0, only lap 0 passes
        set_cfg(8'd255, 16'd0, 1'b1);
        send_random(20);
        go_idle();

        // busy stretch without any idling on either side
        set_cfg(8'd1, 16'd20, 1'b1);
        no_idle = 1'b1;
        send_random(40);
        go_idle();
        no_idle = 1'b0;

        // lower the resolution below the running prescaler count so it must wrap
        set_cfg(8'd200, 16'hffff, 1'b0);
        repeat (30) send_cmd(OP_TICK, 4'd0, 16'd0, 1'b0, 8'd0, 1'b0, 1'b0);
        go_idle();
        cfg_write(REG_TICK_RES, 16'd2);
        repeat (260) send_cmd(OP_TICK, 4'd0, 16'd0, 1'b0, 8'd0, 1'b0, 1'b0);
        go_idle();

        set_cfg(8'd3, 16'hffff, 1'b0);
        send_random(60);
        go_idle();

        $display("Ran %0d input beats over 8 config settings; %0d result beats, %0d fired",
                 n_items, n_beats, n_fired);
        if (errs == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* sim.f */
design/ptts_pkg.sv
design/ptts_front.sv
design/ptts_queue.sv
design/ptts_back.sv
design/priority_task_tick_scheduler.sv
verif/tb_priority_task_tick_scheduler.sv
